// ===== rtl/core/lts_pkg.sv =====
package lts_pkg;

    // Smoothing weight after reset: half new color, half previous color.
    localparam logic [7:0] WEIGHT_RESET = 8'd128;

    // Depth of the request queue between the front and the back.
    localparam int QUEUE_DEPTH = 2;
    localparam int QUEUE_AW    = $clog2(QUEUE_DEPTH);

    typedef struct packed {
        logic [7:0] blue;
        logic [7:0] green;
        logic [7:0] red;
    } t_rgb;

    // A classified request as the front hands it to the back.
    typedef struct packed {
        logic ch_ok;
        logic pos_ok;
        logic frame_end;
        t_rgb color;
    } t_req;

    // Status that the back reports to the front.
    typedef struct packed {
        logic clearing;
    } t_back_status;

    typedef enum logic {
        ST_CLEAR,
        ST_RUN
    } t_back_state;

endpackage

// ===== rtl/core/lts_front.sv =====
module lts_front import lts_pkg::*; #(
    parameter int MAX_LEDS       = 96,
    parameter int MAX_CHANNELS   = 2,
    localparam int DEPTH         = MAX_LEDS * MAX_CHANNELS,
    localparam int ADDR_W        = (DEPTH > 1) ? $clog2(DEPTH) : 1,
    localparam int CH_W          = (MAX_CHANNELS > 1) ? $clog2(MAX_CHANNELS) : 1
) (
    input  logic              i_valid,
    output logic              o_ready,
    input  logic [2:0]        i_channel,
    input  logic [7:0]        i_led_index,
    input  t_rgb              i_color,
    input  logic              i_frame_end,
    input  logic              i_queue_full,
    input  t_back_status      i_back_status,
    output logic              o_push,
    output t_req              o_req,
    output logic [ADDR_W-1:0] o_addr,
    output logic [CH_W-1:0]   o_ch_idx
);

    logic ch_ok;
    logic pos_ok;

    // Requests are taken while the queue has room and the store is not being cleared.
    assign o_ready = !i_queue_full && !i_back_status.clearing;
    assign o_push  = i_valid && o_ready;

    assign ch_ok  = ({1'b0, i_channel} < 4'(MAX_CHANNELS));
    assign pos_ok = ({1'b0, i_led_index} < 9'(MAX_LEDS));

    assign o_ch_idx = i_channel[CH_W-1:0];

    // The address is only meaningful when both checks pass, and then it fits.
    assign o_addr = ADDR_W'(o_ch_idx) * ADDR_W'(MAX_LEDS) + ADDR_W'(i_led_index);

    always_comb begin
        o_req.ch_ok     = ch_ok;
        o_req.pos_ok    = pos_ok;
        o_req.frame_end = i_frame_end;
        o_req.color     = i_color;
    end

endmodule

// ===== rtl/core/lts_queue.sv =====
module lts_queue import lts_pkg::*; #(
    parameter int WIDTH = 32
) (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_push,
    input  logic [WIDTH-1:0] i_data,
    output logic             o_full,
    input  logic             i_pop,
    output logic             o_valid,
    output logic [WIDTH-1:0] o_data
);

    logic [WIDTH-1:0]    r_mem [QUEUE_DEPTH];
    logic [QUEUE_AW-1:0] r_wr_ptr;
    logic [QUEUE_AW-1:0] r_rd_ptr;
    logic [QUEUE_AW:0]   r_count;
    logic [QUEUE_AW-1:0] n_wr_ptr;
    logic [QUEUE_AW-1:0] n_rd_ptr;

    assign o_full  = (r_count == (QUEUE_AW + 1)'(QUEUE_DEPTH));
    assign o_valid = (r_count != '0);
    assign o_data  = r_mem[r_rd_ptr];

    assign n_wr_ptr = (r_wr_ptr == QUEUE_AW'(QUEUE_DEPTH - 1)) ? '0 : r_wr_ptr + 1'b1;
    assign n_rd_ptr = (r_rd_ptr == QUEUE_AW'(QUEUE_DEPTH - 1)) ? '0 : r_rd_ptr + 1'b1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= '0;
            r_rd_ptr <= '0;
            r_count  <= '0;
        end else begin
            if (i_push) begin
                r_wr_ptr <= n_wr_ptr;
            end
            if (i_pop) begin
                r_rd_ptr <= n_rd_ptr;
            end
            case ({i_push, i_pop})
                2'b10:   r_count <= r_count + 1'b1;
                2'b01:   r_count <= r_count - 1'b1;
                default: r_count <= r_count;
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_push) begin
            r_mem[r_wr_ptr] <= i_data;
        end
    end

endmodule

// ===== rtl/core/lts_back.sv =====
module lts_back import lts_pkg::*; #(
    parameter int MAX_LEDS       = 96,
    parameter int MAX_CHANNELS   = 2,
    localparam int DEPTH         = MAX_LEDS * MAX_CHANNELS,
    localparam int ADDR_W        = (DEPTH > 1) ? $clog2(DEPTH) : 1,
    localparam int CH_W          = (MAX_CHANNELS > 1) ? $clog2(MAX_CHANNELS) : 1
) (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_cfg_wr_en,
    input  logic [7:0]        i_cfg_wr_data,
    input  logic              i_q_valid,
    input  t_req              i_req,
    input  logic [ADDR_W-1:0] i_addr,
    input  logic [CH_W-1:0]   i_ch_idx,
    output logic              o_pop,
    output t_back_status      o_status,
    output logic              o_out_valid,
    input  logic              i_out_ready,
    output t_rgb              o_out_color,
    output logic              o_out_last
);

    function automatic logic [7:0] blend(input logic [7:0] w, input logic [7:0] fresh,
                                         input logic [7:0] old);
        logic [15:0] sum;
        sum = 16'(w) * 16'(fresh) + 16'(9'd256 - {1'b0, w}) * 16'(old);
        return sum[15:8];
    endfunction

    t_back_state         r_state;
    t_back_state         n_state;
    logic                clearing;
    logic [ADDR_W-1:0]   r_clr_addr;

    logic [7:0]          r_weight;
    logic [MAX_CHANNELS-1:0] r_primed;

    t_rgb                r_mem [DEPTH];
    t_rgb                r_rdata;

    logic                r_s1_valid;
    t_req                r_s1_req;
    logic [ADDR_W-1:0]   r_s1_addr;
    logic [CH_W-1:0]     r_s1_ch;

    logic                r_fwd_valid;
    logic [ADDR_W-1:0]   r_fwd_addr;
    t_rgb                r_fwd_data;

    logic                r_out_valid;
    t_rgb                r_out_color;
    logic                r_out_last;

    logic                s1_adv;
    logic                in_store;
    logic                smooth;
    logic                item_we;
    t_rgb                prev;
    t_rgb                result;
    logic                mem_we;
    logic [ADDR_W-1:0]   mem_waddr;
    t_rgb                mem_wdata;

    // Clear pass after reset, one entry per cycle.
    always_comb begin
        n_state = r_state;
        case (r_state)
            ST_CLEAR: begin
                if (r_clr_addr == ADDR_W'(DEPTH - 1)) begin
                    n_state = ST_RUN;
                end
            end
            ST_RUN:   n_state = ST_RUN;
            default:  n_state = ST_CLEAR;
        endcase
    end

    always_comb begin
        case (r_state)
            ST_CLEAR: clearing = 1'b1;
            ST_RUN:   clearing = 1'b0;
            default:  clearing = 1'b1;
        endcase
    end

    assign o_status.clearing = clearing;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state    <= ST_CLEAR;
            r_clr_addr <= '0;
        end else begin
            r_state <= n_state;
            if (clearing) begin
                r_clr_addr <= r_clr_addr + 1'b1;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_weight <= WEIGHT_RESET;
        end else if (i_cfg_wr_en) begin
            r_weight <= i_cfg_wr_data;
        end
    end

    // Stage one holds the item whose stored color has just been read.
    assign s1_adv = r_s1_valid && (!r_out_valid || i_out_ready);
    assign o_pop  = !clearing && i_q_valid && (!r_s1_valid || s1_adv);

    // The write of the item ahead can land on the edge this item was read.
    assign prev = (r_fwd_valid && (r_fwd_addr == r_s1_addr)) ? r_fwd_data : r_rdata;

    assign in_store = r_s1_req.ch_ok && r_s1_req.pos_ok;
    assign smooth   = in_store && r_primed[r_s1_ch];
    assign item_we  = s1_adv && in_store;

    always_comb begin
        if (smooth) begin
            result.red   = blend(r_weight, r_s1_req.color.red,   prev.red);
            result.green = blend(r_weight, r_s1_req.color.green, prev.green);
            result.blue  = blend(r_weight, r_s1_req.color.blue,  prev.blue);
        end else begin
            result = r_s1_req.color;
        end
    end

    assign mem_we    = clearing || item_we;
    assign mem_waddr = clearing ? r_clr_addr : r_s1_addr;
    assign mem_wdata = clearing ? '0 : result;

    always_ff @(posedge i_clk) begin
        if (mem_we) begin
            r_mem[mem_waddr] <= mem_wdata;
        end
        if (o_pop) begin
            r_rdata <= r_mem[i_addr];
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s1_valid  <= 1'b0;
            r_fwd_valid <= 1'b0;
            r_out_valid <= 1'b0;
            r_primed    <= '0;
        end else begin
            if (o_pop) begin
                r_s1_valid <= 1'b1;
            end else if (s1_adv) begin
                r_s1_valid <= 1'b0;
            end
            if (item_we) begin
                r_fwd_valid <= 1'b1;
            end
            if (s1_adv) begin
                r_out_valid <= 1'b1;
            end else if (i_out_ready) begin
                r_out_valid <= 1'b0;
            end
            if (s1_adv && r_s1_req.ch_ok && r_s1_req.frame_end) begin
                r_primed[r_s1_ch] <= 1'b1;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (o_pop) begin
            r_s1_req  <= i_req;
            r_s1_addr <= i_addr;
            r_s1_ch   <= i_ch_idx;
        end
        if (item_we) begin
            r_fwd_addr <= r_s1_addr;
            r_fwd_data <= result;
        end
        if (s1_adv) begin
            r_out_color <= result;
            r_out_last  <= r_s1_req.frame_end;
        end
    end

    assign o_out_valid = r_out_valid;
    assign o_out_color = r_out_color;
    assign o_out_last  = r_out_last;

endmodule

// ===== rtl/core/led_temporal_smoothing_top.sv =====
// Channel     Direction  Handshake                      Payload
// s_axis      in         i_s_axis_tvalid/o_s_axis_tready tdata: index, red, green, blue;
//                                                        tuser: channel; tlast: frame end
// m_axis      out        o_m_axis_tvalid/i_m_axis_tready tdata: red, green, blue;
//                                                        tlast: frame end
// cfg         in         i_cfg_wr_en                     i_cfg_wr_data: smoothing weight
//
// One request is accepted per cycle and one result leaves per cycle when nothing stalls.
// A request is taken into the queue, its stored color is read as it leaves the queue, and
// the output register then loads the blended result.
// The rate is set by the single read-modify-write of the color store per request.
// After reset the store is cleared one entry per cycle, and o_s_axis_tready stays low
// until the last entry is cleared.
// A stall at the output holds the result register and backs up into the queue;
// the input keeps accepting until the two-entry queue is full.
module led_temporal_smoothing_top import lts_pkg::*; #(
    parameter int MAX_LEDS     = 96,
    parameter int MAX_CHANNELS = 2
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_cfg_wr_en,
    input  logic [7:0]  i_cfg_wr_data,
    input  logic        i_s_axis_tvalid,
    output logic        o_s_axis_tready,
    input  logic [31:0] i_s_axis_tdata,   // led_index[7:0], red[15:8], green[23:16], blue[31:24]
    input  logic [2:0]  i_s_axis_tuser,   // channel[2:0]
    input  logic        i_s_axis_tlast,
    output logic        o_m_axis_tvalid,
    input  logic        i_m_axis_tready,
    output logic [23:0] o_m_axis_tdata,   // red_out[7:0], green_out[15:8], blue_out[23:16]
    output logic        o_m_axis_tlast
);

    localparam int DEPTH  = MAX_LEDS * MAX_CHANNELS;
    localparam int ADDR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CH_W   = (MAX_CHANNELS > 1) ? $clog2(MAX_CHANNELS) : 1;
    localparam int Q_W    = ADDR_W + CH_W + $bits(t_req);

    // Front to queue.
    logic              push;
    t_req              f_req;
    logic [ADDR_W-1:0] f_addr;
    logic [CH_W-1:0]   f_ch_idx;
    logic              q_full;

    // Queue to back.
    logic              q_valid;
    logic              pop;
    logic [Q_W-1:0]    q_rdata;
    t_req              b_req;
    logic [ADDR_W-1:0] b_addr;
    logic [CH_W-1:0]   b_ch_idx;

    t_back_status      back_status;
    t_rgb              out_color;

    // The front checks the channel and position and forms the store address.
    lts_front #(
        .MAX_LEDS     (MAX_LEDS),
        .MAX_CHANNELS (MAX_CHANNELS)
    ) u_front (
        .i_valid       (i_s_axis_tvalid),
        .o_ready       (o_s_axis_tready),
        .i_channel     (i_s_axis_tuser),
        .i_led_index   (i_s_axis_tdata[7:0]),
        .i_color       (t_rgb'(i_s_axis_tdata[31:8])),
        .i_frame_end   (i_s_axis_tlast),
        .i_queue_full  (q_full),
        .i_back_status (back_status),
        .o_push        (push),
        .o_req         (f_req),
        .o_addr        (f_addr),
        .o_ch_idx      (f_ch_idx)
    );

    lts_queue #(
        .WIDTH (Q_W)
    ) u_queue (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (push),
        .i_data  ({f_addr, f_ch_idx, f_req}),
        .o_full  (q_full),
        .i_pop   (pop),
        .o_valid (q_valid),
        .o_data  (q_rdata)
    );

    assign b_req    = t_req'(q_rdata[$bits(t_req)-1:0]);
    assign b_ch_idx = q_rdata[$bits(t_req) +: CH_W];
    assign b_addr   = q_rdata[$bits(t_req) + CH_W +: ADDR_W];

    // The back reads the old color, blends it in once the channel is primed and writes the result.
    lts_back #(
        .MAX_LEDS     (MAX_LEDS),
        .MAX_CHANNELS (MAX_CHANNELS)
    ) u_back (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_cfg_wr_en   (i_cfg_wr_en),
        .i_cfg_wr_data (i_cfg_wr_data),
        .i_q_valid     (q_valid),
        .i_req         (b_req),
        .i_addr        (b_addr),
        .i_ch_idx      (b_ch_idx),
        .o_pop         (pop),
        .o_status      (back_status),
        .o_out_valid   (o_m_axis_tvalid),
        .i_out_ready   (i_m_axis_tready),
        .o_out_color   (out_color),
        .o_out_last    (o_m_axis_tlast)
    );

    assign o_m_axis_tdata = out_color;

endmodule

// ===== rtl/core/lts_checker.sv =====
module lts_checker (
    input logic        i_clk,
    input logic        i_rst_n,
    input logic        i_s_axis_tvalid,
    input logic        i_s_axis_tready,
    input logic        i_m_axis_tvalid,
    input logic        i_m_axis_tready,
    input logic [23:0] i_m_axis_tdata,
    input logic        i_m_axis_tlast
);

    // The store is cleared after every reset, so no request is taken right after it.
    a_no_accept_after_reset: assert property (@(posedge i_clk)
        !i_rst_n |=> !i_s_axis_tready)
        else $error("input ready right after reset");

    // Reset empties the result register.
    a_no_result_after_reset: assert property (@(posedge i_clk)
        !i_rst_n |=> !i_m_axis_tvalid)
        else $error("result valid right after reset");

    // Without an accepted request during and since reset, no result can appear.
    a_result_needs_request: assert property (@(posedge i_clk)
        (!i_rst_n ##1 (i_rst_n && !(i_s_axis_tvalid && i_s_axis_tready))
         ##1 i_rst_n) |-> !i_m_axis_tvalid)
        else $error("result without a request");

    // A stalled result holds its value.
    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_m_axis_tvalid && !i_m_axis_tready) |=>
        (i_m_axis_tvalid && $stable(i_m_axis_tdata) && $stable(i_m_axis_tlast)))
        else $error("stalled result changed");

endmodule

bind led_temporal_smoothing_top lts_checker u_lts_checker (
    .i_clk           (i_clk),
    .i_rst_n         (i_rst_n),
    .i_s_axis_tvalid (i_s_axis_tvalid),
    .i_s_axis_tready (o_s_axis_tready),
    .i_m_axis_tvalid (o_m_axis_tvalid),
    .i_m_axis_tready (i_m_axis_tready),
    .i_m_axis_tdata  (o_m_axis_tdata),
    .i_m_axis_tlast  (o_m_axis_tlast)
);
